### src/svc_pkg.sv
// Shared types and constants for the spatially variant 3x3 filter.
// No dependencies.
package svc_pkg;

	localparam int PIX_W  = 8;
	localparam int COEF_W = 12;
	localparam int D_W    = 16;
	localparam int ROOT_W = 21;
	localparam int POS_W  = 12;
	localparam int COL_W  = 9;

	// register indexes on the configuration port
	localparam logic [2:0] REG_COEF_LO = 3'd0;
	localparam logic [2:0] REG_COEF_HI = 3'd1;
	localparam logic [2:0] REG_CTR_ROW = 3'd2;
	localparam logic [2:0] REG_CTR_COL = 3'd3;
	localparam logic [2:0] REG_SCALE   = 3'd4;
	localparam logic [2:0] REG_WIDTH   = 3'd5;
	localparam logic [2:0] REG_HEIGHT  = 3'd6;

	// one window column, row 0 on top
	typedef logic [2:0][PIX_W-1:0] col_t;

	typedef struct packed {
		logic             start;
		logic [POS_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [POS_W-1:0] center_row;
		logic [POS_W-1:0] center_col;
		logic [POS_W-1:0] scale;
	} wt_req_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_CALC = 5'b00100,
		S_MUL  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	typedef enum logic [4:0] {
		W_IDLE = 5'b00001,
		W_SUM  = 5'b00010,
		W_SQRT = 5'b00100,
		W_DIV  = 5'b01000,
		W_DONE = 5'b10000
	} wstate_t;

endpackage

### src/svc_col_cell.sv
// One column cell of the 3x3 window; hands its column to the left neighbor.
// Depends on svc_pkg.
module svc_col_cell import svc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  col_t din,
	output col_t dout
);

	col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= din;
		end
	end

	assign dout = col_q;

endmodule

### src/svc_weight.sv
// Distance weight unit: squared distance, bit-serial square root, bit-serial divide.
// Depends on svc_pkg.
module svc_weight import svc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  wt_req_t        req,
	output logic           done,
	output logic [D_W-1:0] weight
);

	wstate_t            state_q;
	logic [4:0]         cnt_q;
	logic [23:0]        sqa_q, sqb_q;
	logic [2*ROOT_W-1:0] x_q;
	logic [24:0]        rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [POS_W-1:0]   scale_q;
	logic [POS_W-1:0]   drem_q;
	logic [ROOT_W-1:0]  quo_q;

	logic signed [12:0] dr, dc;
	logic signed [25:0] sq_r, sq_c;
	logic [24:0]        rem_n, trial;
	logic [12:0]        drem_n;
	logic               last_it;

	assign dr    = $signed({1'b0, req.row}) - $signed({1'b0, req.center_row});
	assign dc    = $signed({2'b0, req.col}) - $signed({1'b0, req.center_col});
	assign sq_r  = dr * dr;
	assign sq_c  = dc * dc;
	assign rem_n = {rem_q[22:0], x_q[2*ROOT_W-1 -: 2]};
	assign trial = {2'b0, root_q, 2'b01};
	assign drem_n = {drem_q, quo_q[ROOT_W-1]};
	assign last_it = (cnt_q == 5'(ROOT_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				W_IDLE: if (req.start) state_q <= W_SUM;
				W_SUM: begin
					cnt_q   <= '0;
					state_q <= W_SQRT;
				end
				W_SQRT: begin
					cnt_q <= last_it ? '0 : cnt_q + 5'd1;
					if (last_it) state_q <= W_DIV;
				end
				W_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (last_it) state_q <= W_DONE;
				end
				W_DONE: state_q <= W_IDLE;
				default: state_q <= W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			W_IDLE: begin
				sqa_q   <= sq_r[23:0];
				sqb_q   <= sq_c[23:0];
				scale_q <= req.scale;
			end
			W_SUM: begin
				x_q    <= {1'b0, 25'(sqa_q) + 25'(sqb_q), 16'b0};
				rem_q  <= '0;
				root_q <= '0;
			end
			W_SQRT: begin
				x_q <= {x_q[2*ROOT_W-3:0], 2'b00};
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				if (last_it) drem_q <= '0;
				if (last_it) quo_q  <= (rem_n >= trial) ? {root_q[ROOT_W-2:0], 1'b1}
				                                        : {root_q[ROOT_W-2:0], 1'b0};
			end
			W_DIV: begin
				// quotient bits shift in as dividend bits shift out
				if (drem_n >= {1'b0, scale_q}) begin
					drem_q <= 12'(drem_n - {1'b0, scale_q});
					quo_q  <= {quo_q[ROOT_W-2:0], 1'b1};
				end else begin
					drem_q <= drem_n[POS_W-1:0];
					quo_q  <= {quo_q[ROOT_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign done   = (state_q == W_DONE);
	assign weight = (scale_q == '0 || quo_q[ROOT_W-1:D_W] != '0) ? {D_W{1'b1}}
	                                                               : quo_q[D_W-1:0];

endmodule

### src/spatially_variant_convolution.sv
// Top level of the spatially variant 3x3 filter.
// Depends on svc_pkg, svc_col_cell, svc_weight.
//
// Filters a raster of 8-bit pixels, blending from identity toward a 3x3 kernel by
// d = distance from (center_row, center_col) / dist_scale, in UQ8.8, saturated to all ones.
// Results (Q.8, saturated to 32 bits) come out in raster order one row plus one
// pixel behind the input, so send active_width+1 flush transfers after a frame.
// One item is processed at a time; an item that yields a result waits on the
// bit-serial square root and divide (21 steps each) in the weight unit.
// The window is a chain of three column cells; two line memories of LINE_WIDTH
// pixels hold the previous rows. A finished result waits in the output
// register while the next item is taken.
module spatially_variant_convolution import svc_pkg::*; #(
	parameter int LINE_WIDTH = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PIX_W-1:0]   pixel,
	input  logic               flush,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic [POS_W-1:0]   out_row,
	output logic [COL_W-1:0]   out_col,
	output logic               last_pixel,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [59:0]        cfg_data
);

	localparam int W_LIM = (LINE_WIDTH < 512) ? LINE_WIDTH : 512;
	localparam int AW    = $clog2(LINE_WIDTH);
	localparam logic signed [41:0] SAT_MAX = 42'sd2147483647;
	localparam logic signed [41:0] SAT_MIN = -42'sd2147483648;

	// configuration
	logic [59:0]      coef_lo_q;
	logic [47:0]      coef_hi_q;
	logic [POS_W-1:0] center_row_q, center_col_q, dist_scale_q, active_height_q;
	logic [9:0]       active_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_lo_q       <= 60'h100_0000_0000_0000;
			coef_hi_q       <= '0;
			center_row_q    <= '0;
			center_col_q    <= '0;
			dist_scale_q    <= 12'd10;
			active_width_q  <= 10'd512;
			active_height_q <= 12'd512;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_LO: coef_lo_q       <= cfg_data;
				REG_COEF_HI: coef_hi_q       <= cfg_data[47:0];
				REG_CTR_ROW: center_row_q    <= cfg_data[11:0];
				REG_CTR_COL: center_col_q    <= cfg_data[11:0];
				REG_SCALE:   dist_scale_q    <= cfg_data[11:0];
				REG_WIDTH:   active_width_q  <= cfg_data[9:0];
				REG_HEIGHT:  active_height_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// effective frame size
	logic [9:0]       w_eff;
	logic [POS_W-1:0] h_eff;
	assign w_eff = (active_width_q == '0) ? 10'd1 :
	               (active_width_q > 10'(W_LIM)) ? 10'(W_LIM) : active_width_q;
	assign h_eff = (active_height_q == '0) ? 12'd1 : active_height_q;

	// kernel taps as a 3x3 array
	logic signed [COEF_W-1:0] coef_m [3][3];
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			if (i < 5) coef_m[i/3][i%3] = $signed(coef_lo_q[12*i +: 12]);
			else       coef_m[i/3][i%3] = $signed(coef_hi_q[12*(i-5) +: 12]);
		end
	end

	state_t state_q;
	logic   accept;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// position counters; in_row only needs to tell 0, 1 and 2-or-more
	logic [1:0]       in_row_q;
	logic [COL_W-1:0] in_col_q, emit_col_q;
	logic [POS_W-1:0] emit_row_q;

	logic [COL_W-1:0] col, ec;
	logic [COL_W-1:0] w_max;
	logic             emit, col_wrap, last, ec_wrap;
	assign w_max    = 9'(w_eff - 10'd1);
	assign col      = ({1'b0, in_col_q} < w_eff) ? in_col_q : w_max;
	assign emit     = (in_col_q != '0) ? (in_row_q >= 2'd1) : (in_row_q >= 2'd2);
	assign col_wrap = ({1'b0, in_col_q} + 10'd1 >= w_eff);
	assign ec       = ({1'b0, emit_col_q} < w_eff) ? emit_col_q : w_max;
	assign ec_wrap  = ({1'b0, ec} + 10'd1 >= w_eff);
	assign last     = ({1'b0, emit_row_q} + 13'd1 >= {1'b0, h_eff}) && ec_wrap;

	// latched item
	logic [PIX_W-1:0] pix_q, up2_q, up1_q;
	logic [COL_W-1:0] col_q, ec_q;
	logic [POS_W-1:0] er_q;
	logic             emit_q, last_q;
	logic [2:0]       row_ok_q, col_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			emit_row_q <= '0;
			emit_col_q <= '0;
			emit_q     <= 1'b0;
		end else if (accept) begin
			emit_q <= emit;
			if (emit && last) begin
				in_row_q   <= '0;
				in_col_q   <= '0;
				emit_row_q <= '0;
				emit_col_q <= '0;
			end else begin
				if (col_wrap) begin
					in_col_q <= '0;
					if (in_row_q != 2'd2) in_row_q <= in_row_q + 2'd1;
				end else begin
					in_col_q <= in_col_q + 9'd1;
				end
				if (emit) begin
					if (ec_wrap) begin
						emit_col_q <= '0;
						emit_row_q <= emit_row_q + 12'd1;
					end else begin
						emit_col_q <= ec + 9'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q    <= flush ? '0 : pixel;
			col_q    <= col;
			er_q     <= emit_row_q;
			ec_q     <= ec;
			last_q   <= last;
			row_ok_q <= {({1'b0, emit_row_q} + 13'd1 < {1'b0, h_eff}),
			             (emit_row_q < h_eff), (emit_row_q != '0)};
			col_ok_q <= {({1'b0, ec} + 10'd1 < w_eff), ({1'b0, ec} < w_eff), (ec != '0)};
		end
	end

	// line memories: row above-above and row above
	logic [PIX_W-1:0] mem_a [LINE_WIDTH];
	logic [PIX_W-1:0] mem_b [LINE_WIDTH];

	always_ff @(posedge clk) begin
		if (accept) begin
			up2_q <= mem_a[AW'(col)];
			up1_q <= mem_b[AW'(col)];
		end
		if (state_q == S_READ) begin
			mem_a[AW'(col_q)] <= up1_q;
			mem_b[AW'(col_q)] <= pix_q;
		end
	end

	// window: chain of column cells, win[2] newest
	col_t win [3];
	logic shift;
	assign shift = (state_q == S_READ);

	svc_col_cell u_cell2 (.clk, .arst_n, .shift, .din({pix_q, up1_q, up2_q}), .dout(win[2]));
	svc_col_cell u_cell1 (.clk, .arst_n, .shift, .din(win[2]), .dout(win[1]));
	svc_col_cell u_cell0 (.clk, .arst_n, .shift, .din(win[1]), .dout(win[0]));

	// weight unit
	wt_req_t        wt_req;
	logic           wt_done;
	logic [D_W-1:0] wt_val;

	assign wt_req = '{start: (state_q == S_READ) && emit_q, row: er_q, col: ec_q,
	                  center_row: center_row_q, center_col: center_col_q,
	                  scale: dist_scale_q};

	svc_weight u_weight (.clk, .arst_n, .req(wt_req), .done(wt_done), .weight(wt_val));

	// tap sequencer: one tap product per cycle
	logic [1:0]         kr_q, kc_q;
	logic               conv_done_q, wt_have_q;
	logic signed [24:0] acc_q;
	logic [D_W-1:0]     d_q;
	logic signed [20:0] tap_prod;
	logic [PIX_W-1:0]   tap_pix, ctr;
	logic signed [24:0] diff;
	logic signed [41:0] prod_q, qv, res;
	logic               load_out;

	assign tap_pix  = win[kc_q][kr_q];
	assign tap_prod = coef_m[kr_q][kc_q] * $signed({1'b0, tap_pix});
	assign ctr      = win[1][1];
	assign diff     = acc_q - $signed({9'b0, ctr, 8'b0});
	assign qv       = prod_q >>> 8;
	assign res      = qv + $signed({26'b0, ctr, 8'b0});
	// output register free or being emptied this cycle
	assign load_out = (state_q == S_FIN) && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kr_q        <= '0;
			kc_q        <= '0;
			conv_done_q <= 1'b0;
			wt_have_q   <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (load_out) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (accept) state_q <= S_READ;
				S_READ: begin
					kr_q        <= '0;
					kc_q        <= '0;
					conv_done_q <= 1'b0;
					wt_have_q   <= 1'b0;
					state_q     <= emit_q ? S_CALC : S_IDLE;
				end
				S_CALC: begin
					if (!conv_done_q) begin
						if (kc_q == 2'd2) begin
							kc_q <= '0;
							kr_q <= kr_q + 2'd1;
							if (kr_q == 2'd2) conv_done_q <= 1'b1;
						end else begin
							kc_q <= kc_q + 2'd1;
						end
					end
					if (wt_done) wt_have_q <= 1'b1;
					if (conv_done_q && wt_have_q) state_q <= S_MUL;
				end
				S_MUL: state_q <= S_FIN;
				S_FIN: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ) acc_q <= '0;
		else if (state_q == S_CALC && !conv_done_q && row_ok_q[kr_q] && col_ok_q[kc_q])
			acc_q <= acc_q + 25'(tap_prod);
		if (wt_done) d_q <= wt_val;
		if (state_q == S_MUL) prod_q <= diff * $signed({1'b0, d_q});
		if (load_out) begin
			value      <= (res > SAT_MAX) ? 32'sh7FFF_FFFF :
			              (res < SAT_MIN) ? -32'sh8000_0000 : res[31:0];
			out_row    <= er_q;
			out_col    <= ec_q;
			last_pixel <= last_q;
		end
	end

	// one item in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("item taken while another is in work");

	// weight result arrives only in the calculation state
	a_wt_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		wt_done |-> (state_q == S_CALC))
		else $error("weight finished outside the calculation phase");

	// a result is loaded only from the final stage
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FIN))
		else $error("result loaded from an unexpected state");

endmodule
